[rtl/core/vtpg_pkg.sv]
// vtpg_pkg: shared types, field widths and codes for the rectangle test pattern generator
// no dependencies; imported by vtpg_color_pipe and video_test_pattern_generator_unit

package vtpg_pkg;

   localparam int PIX_W       = 12;
   localparam int CSR_RES_W   = 13;
   localparam int CSR_CELLS_W = 8;
   localparam int COLOR_W     = 32;
   localparam int STEP_W      = 8;
   localparam int MODEL_W     = 2;
   localparam int BITS_W      = 6;
   localparam int ADDR_W      = 26;
   localparam int COUNT_W     = 3;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam int DIV_STEPS   = 4;
   localparam int COLOR_LAT   = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_H_RES       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_V_RES       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_COLOR = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_STEP  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_MODEL = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_BITS  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAYOUT      = 3'd7;

   localparam logic [MODEL_W-1:0] MODEL_INDEXED = 2'd0;
   localparam logic [MODEL_W-1:0] MODEL_DIRECT  = 2'd1;

   localparam logic [STATUS_W-1:0] STATUS_DRAWN      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OFF_GRID   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OFF_SCREEN = 2'd2;

   typedef struct packed {
      logic [7:0] b_pos;
      logic [7:0] b_size;
      logic [7:0] g_pos;
      logic [7:0] g_size;
      logic [7:0] r_pos;
      logic [7:0] r_size;
   } layout_type;

   typedef struct packed {
      logic [CSR_RES_W-1:0]   h_res;
      logic [CSR_RES_W-1:0]   v_res;
      logic [CSR_CELLS_W-1:0] cells;
      logic [COLOR_W-1:0]     first_color;
      logic [STEP_W-1:0]      color_step;
      logic [MODEL_W-1:0]     color_model;
      logic [BITS_W-1:0]      pixel_bits;
      layout_type             layout;
   } csr_regs_type;

   localparam csr_regs_type CSR_RESET = '{
      h_res:       13'd1024,
      v_res:       13'd768,
      cells:       8'd1,
      first_color: 32'd0,
      color_step:  8'd0,
      color_model: MODEL_INDEXED,
      pixel_bits:  6'd8,
      layout:      48'd0
   };

   typedef struct packed {
      logic [PIX_W-1:0] pixel_x;
      logic [PIX_W-1:0] pixel_y;
   } pixel_req_type;

   typedef struct packed {
      logic [COLOR_W-1:0]  pixel_color;
      logic [ADDR_W-1:0]   byte_address;
      logic [COUNT_W-1:0]  byte_count;
      logic [STATUS_W-1:0] status;
   } pixel_rsp_type;

   typedef struct packed {
      logic valid;
      logic off_screen;
   } track_type;

endpackage

[rtl/core/vtpg_div_pipe.sv]
// vtpg_div_pipe: pipelined restoring divider, STEPS quotient bits per stage
// no package dependencies; used by the top level for cell size and cell index

module vtpg_div_pipe #(
   parameter int NUM_W = 13,
   parameter int DEN_W = 8,
   parameter int STEPS = 4
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [NUM_W-1:0] quotient
);

   localparam int LAT = (NUM_W + STEPS - 1) / STEPS;

   logic [DEN_W-1:0] rem_ff  [LAT];
   logic [DEN_W-1:0] rem_in  [LAT];
   logic [NUM_W-1:0] acc_ff  [LAT];
   logic [NUM_W-1:0] acc_in  [LAT];
   logic [DEN_W-1:0] den_ff  [LAT];
   logic [DEN_W-1:0] rem_src [LAT];
   logic [NUM_W-1:0] acc_src [LAT];
   logic [DEN_W-1:0] den_src [LAT];

   always_comb begin
      rem_src[0] = '0;
      acc_src[0] = dividend;
      den_src[0] = divisor;
      for (int s = 1; s < LAT; s++) begin
         rem_src[s] = rem_ff[s-1];
         acc_src[s] = acc_ff[s-1];
         den_src[s] = den_ff[s-1];
      end
   end

   // shift one dividend bit into the remainder per step, quotient bits enter at the bottom
   always_comb begin
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] acc;
      logic [DEN_W:0]   trial;
      rem   = '0;
      acc   = '0;
      trial = '0;
      for (int s = 0; s < LAT; s++) begin
         rem = rem_src[s];
         acc = acc_src[s];
         for (int t = 0; t < STEPS; t++) begin
            if (s * STEPS + t < NUM_W) begin
               trial = {rem, acc[NUM_W-1]};
               acc   = {acc[NUM_W-2:0], 1'b0};
               if (trial >= {1'b0, den_src[s]}) begin
                  trial  = trial - {1'b0, den_src[s]};
                  acc[0] = 1'b1;
               end
               rem = trial[DEN_W-1:0];
            end
         end
         rem_in[s] = rem;
         acc_in[s] = acc;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < LAT; s++) begin
         rem_ff[s] <= rem_in[s];
         acc_ff[s] <= acc_in[s];
         den_ff[s] <= den_src[s];
      end
   end

   assign quotient = acc_ff[LAT-1];

endmodule

[rtl/core/vtpg_color_pipe.sv]
// vtpg_color_pipe: four-stage color datapath, indexed, direct and constant color models
// depends on vtpg_pkg for the register struct, widths and model codes

module vtpg_color_pipe import vtpg_pkg::*; (
   input  logic                   clock,
   input  csr_regs_type           cfg,
   input  logic [CSR_CELLS_W-1:0] row,
   input  logic [CSR_CELLS_W-1:0] col,
   input  logic                   drawn,
   output logic [COLOR_W-1:0]     color
);

   function automatic logic [COLOR_W-1:0] low_mask(input logic [7:0] n);
      low_mask = (n >= 8'd32) ? '1 : ((COLOR_W'(1) << n[4:0]) - COLOR_W'(1));
   endfunction

   function automatic logic [COLOR_W-1:0] pack_chan(
      input logic [COLOR_W-1:0] base,
      input logic [COLOR_W-1:0] add,
      input logic [7:0]         size,
      input logic [7:0]         pos
   );
      logic [COLOR_W-1:0] sum;
      sum       = (base + add) & low_mask(size);
      pack_chan = (pos >= 8'd32) ? '0 : (sum << pos[4:0]);
   endfunction

   logic [CSR_CELLS_W:0] pair_sum;
   logic [15:0]          in_prod_ff;
   logic [15:0]          col_step1_ff;
   logic [15:0]          row_step1_ff;
   logic [16:0]          sum_step1_ff;
   logic [7:0]           col1_ff;
   logic                 drawn1_ff;

   logic [15:0]          idx2_ff;
   logic [15:0]          col_step2_ff;
   logic [15:0]          row_step2_ff;
   logic [16:0]          sum_step2_ff;
   logic [COLOR_W-1:0]   base_r_ff;
   logic [COLOR_W-1:0]   base_g_ff;
   logic [COLOR_W-1:0]   base_b_ff;
   logic                 drawn2_ff;

   logic [23:0]          idx_step3_ff;
   logic [COLOR_W-1:0]   direct3_ff;
   logic                 drawn3_ff;

   logic [COLOR_W-1:0]   sel_color;
   logic [COLOR_W-1:0]   color_ff;

   assign pair_sum = (CSR_CELLS_W + 1)'(row) + (CSR_CELLS_W + 1)'(col);

   // products of cell position with the cell count and with the step
   always_ff @(posedge clock) begin
      in_prod_ff   <= 16'(row) * 16'(cfg.cells);
      col_step1_ff <= 16'(col) * 16'(cfg.color_step);
      row_step1_ff <= 16'(row) * 16'(cfg.color_step);
      sum_step1_ff <= 17'(pair_sum) * 17'(cfg.color_step);
      col1_ff      <= col;
      drawn1_ff    <= drawn;
   end

   // cell number and channel extraction
   always_ff @(posedge clock) begin
      idx2_ff      <= in_prod_ff + 16'(col1_ff);
      col_step2_ff <= col_step1_ff;
      row_step2_ff <= row_step1_ff;
      sum_step2_ff <= sum_step1_ff;
      base_r_ff    <= (cfg.first_color >> cfg.layout.r_pos[4:0]) & low_mask(cfg.layout.r_size);
      base_g_ff    <= (cfg.first_color >> cfg.layout.g_pos[4:0]) & low_mask(cfg.layout.g_size);
      base_b_ff    <= (cfg.first_color >> cfg.layout.b_pos[4:0]) & low_mask(cfg.layout.b_size);
      drawn2_ff    <= drawn1_ff;
   end

   always_ff @(posedge clock) begin
      idx_step3_ff <= 24'(idx2_ff) * 24'(cfg.color_step);
      direct3_ff   <= pack_chan(base_r_ff, COLOR_W'(col_step2_ff),
                                cfg.layout.r_size, cfg.layout.r_pos)
                    | pack_chan(base_g_ff, COLOR_W'(row_step2_ff),
                                cfg.layout.g_size, cfg.layout.g_pos)
                    | pack_chan(base_b_ff, COLOR_W'(sum_step2_ff),
                                cfg.layout.b_size, cfg.layout.b_pos);
      drawn3_ff    <= drawn2_ff;
   end

   always_comb begin
      case (cfg.color_model)
         MODEL_INDEXED: sel_color = cfg.first_color + COLOR_W'(idx_step3_ff);
         MODEL_DIRECT:  sel_color = direct3_ff;
         default:       sel_color = cfg.first_color;
      endcase
   end

   always_ff @(posedge clock) begin
      color_ff <= drawn3_ff ? (sel_color & low_mask(8'(cfg.pixel_bits))) : '0;
   end

   assign color = color_ff;

endmodule

[rtl/core/video_test_pattern_generator_unit.sv]
// video_test_pattern_generator_unit: one pixel per clock while not busy; an accepted beat passes
// delays matching the cell-size divide, then the cell-index divide and the color stages, before its strobe;
// busy follows reset, so no beat is taken in reset
// synchronous reset restores the register defaults and drops every beat in flight
// the receiver cannot stall; each result is on the rsp ports for exactly one cycle
// depends on vtpg_pkg, vtpg_div_pipe and vtpg_color_pipe

module video_test_pattern_generator_unit import vtpg_pkg::*; #(
   parameter int MAX_RESOLUTION = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pixel_req_type          req_pixel,
   output logic                   rsp_strobe,
   output pixel_rsp_type          rsp_result,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int RES_LOG    = $clog2(MAX_RESOLUTION + 1);
   localparam int RES_W      = (RES_LOG < CSR_RES_W) ? RES_LOG : CSR_RES_W;
   localparam logic [RES_W-1:0] RES_CAP =
      (MAX_RESOLUTION >= (1 << RES_W)) ? {RES_W{1'b1}} : RES_W'(MAX_RESOLUTION);
   localparam int LAT_RES    = (RES_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int LAT_PIX    = (PIX_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_DONE   = LAT_RES + LAT_PIX;
   localparam int LAT        = DIV_DONE + COLOR_LAT;
   localparam int PROD_W     = PIX_W + RES_W;
   localparam int ADDR_STAGE = 4;

   csr_regs_type        cfg_ff;
   csr_regs_type        cfg_in;
   logic [RES_W-1:0]    h_res;
   logic [RES_W-1:0]    v_res;
   logic [BITS_W-1:0]   bits_clamped;
   logic [COUNT_W-1:0]  bytes;
   logic                accept;
   logic                off_in;

   track_type           trk_ff [1:LAT-1];
   pixel_req_type       xy_ff  [1:LAT_RES];

   logic [RES_W-1:0]    cell_w;
   logic [RES_W-1:0]    cell_h;
   logic [PIX_W-1:0]    col_idx;
   logic [PIX_W-1:0]    row_idx;
   logic                off_grid;
   logic                drawn;
   logic [COLOR_W-1:0]  color;

   logic [PROD_W-1:0]   prod_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [ADDR_W-1:0]   addr_in;
   logic [ADDR_W-1:0]   addr_ff [ADDR_STAGE:LAT-1];
   logic                grid_ff [DIV_DONE+1:LAT-1];

   logic                rsp_strobe_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [ADDR_W-1:0]   addr_out_ff;
   logic [COUNT_W-1:0]  count_ff;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_H_RES:       cfg_in.h_res       = csr_data[CSR_RES_W-1:0];
            CSR_V_RES:       cfg_in.v_res       = csr_data[CSR_RES_W-1:0];
            CSR_CELLS:       cfg_in.cells       = csr_data[CSR_CELLS_W-1:0];
            CSR_FIRST_COLOR: cfg_in.first_color = csr_data[COLOR_W-1:0];
            CSR_COLOR_STEP:  cfg_in.color_step  = csr_data[STEP_W-1:0];
            CSR_COLOR_MODEL: cfg_in.color_model = csr_data[MODEL_W-1:0];
            CSR_PIXEL_BITS:  cfg_in.pixel_bits  = csr_data[BITS_W-1:0];
            CSR_LAYOUT:      cfg_in.layout      = csr_data;
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CSR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign h_res = (cfg_ff.h_res > CSR_RES_W'(RES_CAP)) ? RES_CAP : cfg_ff.h_res[RES_W-1:0];
   assign v_res = (cfg_ff.v_res > CSR_RES_W'(RES_CAP)) ? RES_CAP : cfg_ff.v_res[RES_W-1:0];
   assign bits_clamped = (cfg_ff.pixel_bits > 6'd32) ? 6'd32 : cfg_ff.pixel_bits;
   assign bytes = COUNT_W'((bits_clamped + 6'd7) >> 3);

   assign busy   = reset;
   assign accept = start && !busy;
   assign off_in = (CSR_RES_W'(req_pixel.pixel_x) >= CSR_RES_W'(h_res))
                || (CSR_RES_W'(req_pixel.pixel_y) >= CSR_RES_W'(v_res));

   // valid and off-screen flag per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LAT - 1; k++) begin
            trk_ff[k] <= '0;
         end
      end else begin
         trk_ff[1] <= '{valid: accept, off_screen: off_in};
         for (int k = 2; k <= LAT - 1; k++) begin
            trk_ff[k] <= trk_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      xy_ff[1] <= req_pixel;
      for (int k = 2; k <= LAT_RES; k++) begin
         xy_ff[k] <= xy_ff[k-1];
      end
   end

   // cell size, then cell index
   vtpg_div_pipe #(
      .NUM_W (RES_W),
      .DEN_W (CSR_CELLS_W),
      .STEPS (DIV_STEPS)
   ) u_div_cell_w (
      .clock    (clock),
      .dividend (h_res),
      .divisor  (cfg_ff.cells),
      .quotient (cell_w)
   );

   vtpg_div_pipe #(
      .NUM_W (RES_W),
      .DEN_W (CSR_CELLS_W),
      .STEPS (DIV_STEPS)
   ) u_div_cell_h (
      .clock    (clock),
      .dividend (v_res),
      .divisor  (cfg_ff.cells),
      .quotient (cell_h)
   );

   vtpg_div_pipe #(
      .NUM_W (PIX_W),
      .DEN_W (RES_W),
      .STEPS (DIV_STEPS)
   ) u_div_col (
      .clock    (clock),
      .dividend (xy_ff[LAT_RES].pixel_x),
      .divisor  (cell_w),
      .quotient (col_idx)
   );

   vtpg_div_pipe #(
      .NUM_W (PIX_W),
      .DEN_W (RES_W),
      .STEPS (DIV_STEPS)
   ) u_div_row (
      .clock    (clock),
      .dividend (xy_ff[LAT_RES].pixel_y),
      .divisor  (cell_h),
      .quotient (row_idx)
   );

   // no cells, zero-size cells or the remainder strip
   assign off_grid = (cfg_ff.cells == '0)
                  || (CSR_RES_W'(cfg_ff.cells) > CSR_RES_W'(h_res))
                  || (CSR_RES_W'(cfg_ff.cells) > CSR_RES_W'(v_res))
                  || (col_idx >= PIX_W'(cfg_ff.cells))
                  || (row_idx >= PIX_W'(cfg_ff.cells));
   assign drawn = !trk_ff[DIV_DONE].off_screen && !off_grid;

   vtpg_color_pipe u_color (
      .clock (clock),
      .cfg   (cfg_ff),
      .row   (row_idx[CSR_CELLS_W-1:0]),
      .col   (col_idx[CSR_CELLS_W-1:0]),
      .drawn (drawn),
      .color (color)
   );

   always_ff @(posedge clock) begin
      grid_ff[DIV_DONE+1] <= off_grid;
      for (int k = DIV_DONE + 2; k <= LAT - 1; k++) begin
         grid_ff[k] <= grid_ff[k-1];
      end
   end

   // byte address
   always_comb begin
      case (bytes)
         3'd1:    addr_in = base_ff;
         3'd2:    addr_in = base_ff << 1;
         3'd3:    addr_in = base_ff + (base_ff << 1);
         3'd4:    addr_in = base_ff << 2;
         default: addr_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff             <= PROD_W'(xy_ff[1].pixel_y) * PROD_W'(h_res);
      base_ff             <= ADDR_W'(prod_ff) + ADDR_W'(xy_ff[2].pixel_x);
      addr_ff[ADDR_STAGE] <= addr_in;
      for (int k = ADDR_STAGE + 1; k <= LAT - 1; k++) begin
         addr_ff[k] <= addr_ff[k-1];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= trk_ff[LAT-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (trk_ff[LAT-1].off_screen) begin
         status_ff <= STATUS_OFF_SCREEN;
      end else if (grid_ff[LAT-1]) begin
         status_ff <= STATUS_OFF_GRID;
      end else begin
         status_ff <= STATUS_DRAWN;
      end
      addr_out_ff <= trk_ff[LAT-1].off_screen ? '0 : addr_ff[LAT-1];
      count_ff    <= bytes;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_result = '{
      pixel_color:  color,
      byte_address: addr_out_ff,
      byte_count:   count_ff,
      status:       status_ff
   };

   a_beat_gives_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_strobe)
      else $error("accepted beat produced no result");

   a_result_has_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result strobe without an accepted beat");

   a_off_screen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_result.status == STATUS_OFF_SCREEN)
         |-> (rsp_result.pixel_color == '0) && (rsp_result.byte_address == '0))
      else $error("off-screen result carries color or address");

endmodule
